>>> hdl/cqr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqr_pkg
// Shared types and codes for the circle quadrant rasterizer.
// ----------------------------------------------------------------------------
package cqr_pkg;

	localparam int unsigned RADIUS_W = 8;
	localparam int unsigned COORD_W  = 15;
	localparam int unsigned PIX_W    = 16;
	localparam int unsigned COLOR_W  = 32;

	// input op codes
	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	// walk phase inside a quadrant
	localparam logic [1:0] PH_OUTLINE = 2'd0;
	localparam logic [1:0] PH_MIRROR  = 2'd1;
	localparam logic [1:0] PH_FILL    = 2'd2;

	// controller -> datapath
	typedef struct packed {
		logic start;       // latch a new circle
		logic ol_cmp;      // commit the outline row decision
		logic wr_a;        // span write at the current row
		logic wr_b;        // span write at the mirrored row
		logic emit_pix;    // load a pixel into the output register
		logic emit_done;   // load the done marker, end the circle
		logic fill_begin;  // enter fill at row one
		logic next_row;    // fill: advance to the next row
		logic next_quad;   // advance to the next quadrant
	} cqr_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic       active;
		logic [1:0] phase;
		logic       col_ge_r;
		logic       row_ge_r;
		logic       ol_end;
		logic       fill;
		logic       quad_last;
		logic       span_more;
	} cqr_stat_t;

endpackage

>>> hdl/cqr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqr_ctrl
// Sequencer: runs one step request through the outline / fill walk and owns
// both handshakes.
// ----------------------------------------------------------------------------
module cqr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              op,
	output logic              out_valid,
	input  logic              out_stall,
	input  cqr_pkg::cqr_stat_t stat,
	output cqr_pkg::cqr_cmd_t  cmd
);

	typedef enum logic [9:0] {
		S_IDLE   = 10'b00_0000_0001,
		S_DISP   = 10'b00_0000_0010,
		S_OL_CMP = 10'b00_0000_0100,
		S_OL_WA  = 10'b00_0000_1000,
		S_OL_WB  = 10'b00_0001_0000,
		S_OL_END = 10'b00_0010_0000,
		S_FL_RD  = 10'b00_0100_0000,
		S_ENDQ   = 10'b00_1000_0000,
		S_EMIT   = 10'b01_0000_0000,
		S_FIN    = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (op == cqr_pkg::OP_START) begin
						cmd.start = 1'b1;
					end else if (stat.active) begin
						state_d = S_DISP;
					end
				end
			end
			S_DISP: begin
				case (stat.phase)
					cqr_pkg::PH_OUTLINE: state_d = stat.col_ge_r ? S_OL_END : S_OL_CMP;
					cqr_pkg::PH_MIRROR:  state_d = S_EMIT;
					cqr_pkg::PH_FILL:    state_d = stat.row_ge_r ? S_ENDQ : S_FL_RD;
					default:             state_d = S_ENDQ;
				endcase
			end
			S_OL_CMP: begin
				cmd.ol_cmp = 1'b1;
				state_d    = stat.ol_end ? S_OL_END : S_OL_WA;
			end
			S_OL_WA: begin
				cmd.wr_a = 1'b1;
				state_d  = S_OL_WB;
			end
			S_OL_WB: begin
				cmd.wr_b = 1'b1;
				state_d  = S_EMIT;
			end
			S_OL_END: begin
				if (stat.fill) begin
					cmd.fill_begin = 1'b1;
					state_d        = S_DISP;
				end else begin
					state_d = S_ENDQ;
				end
			end
			S_FL_RD: begin
				if (stat.span_more) begin
					state_d = S_EMIT;
				end else begin
					cmd.next_row = 1'b1;
					state_d      = S_DISP;
				end
			end
			S_ENDQ: begin
				if (stat.quad_last) begin
					state_d = S_FIN;
				end else begin
					cmd.next_quad = 1'b1;
					state_d       = S_DISP;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					cmd.emit_pix = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_FIN: begin
				if (out_free) begin
					cmd.emit_done = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit_pix || cmd.emit_done) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> hdl/cqr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cqr_datapath
// Circle registers, walk counters, square terms, span memory and the output
// register.
// ----------------------------------------------------------------------------
module cqr_datapath #(
	parameter int unsigned MAX_RADIUS = 255
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cqr_pkg::cqr_cmd_t   cmd,
	output cqr_pkg::cqr_stat_t  stat,
	input  logic signed [14:0]  center_x,
	input  logic signed [14:0]  center_y,
	input  logic [7:0]          radius,
	input  logic [31:0]         color,
	input  logic                fill_enable,
	output logic signed [15:0]  pixel_x,
	output logic signed [15:0]  pixel_y,
	output logic [31:0]         pixel_color,
	output logic                done_res
);

	localparam int unsigned SPAN_DEPTH = (MAX_RADIUS < 255) ? MAX_RADIUS : 255;
	localparam int unsigned SPAN_AW    = (SPAN_DEPTH > 1) ? $clog2(SPAN_DEPTH) : 1;

	// control state
	logic       active_q;
	logic [1:0] quad_q;
	logic [1:0] phase_q;
	logic [7:0] col_q, row_q, spc_q;

	// circle payload
	logic signed [14:0] cx_q, cy_q;
	logic [7:0]         r_q;
	logic [31:0]        color_q;
	logic               fill_q;
	logic [15:0]        r_sq_q, c_sq_q, h_sq_q;
	logic [7:0]         rd_q;

	logic [7:0] span_mem [0:SPAN_DEPTH-1];

	logic [7:0]  r_sat;
	logic [7:0]  h_w;
	logic [16:0] sq_sum, sq_lim;
	logic        row_inc;
	logic [7:0]  row_new;
	logic [7:0]  mir_a;        // r - row - 1
	logic [7:0]  mir_b;        // r - col - 1
	logic [7:0]  off_a, off_b;
	logic [15:0] cx16, cy16, r16, a16, b16;
	logic [15:0] px_w, py_w;

	assign r_sat = (int'(radius) > MAX_RADIUS) ? MAX_RADIUS[7:0] : radius;
	assign h_w   = r_q - row_q;

	// row steps when col^2 + h^2 - 1 > r^2
	assign sq_sum  = {1'b0, c_sq_q} + {1'b0, h_sq_q};
	assign sq_lim  = {1'b0, r_sq_q} + 17'd1;
	assign row_inc = sq_sum > sq_lim;
	assign row_new = row_q + {7'd0, row_inc};

	assign mir_a = r_q - row_q - 8'd1;
	assign mir_b = r_q - col_q - 8'd1;

	always_comb begin
		case (phase_q)
			cqr_pkg::PH_OUTLINE: begin
				off_a = col_q;
				off_b = row_q;
			end
			cqr_pkg::PH_MIRROR: begin
				off_a = mir_a;
				off_b = mir_b;
			end
			default: begin
				off_a = spc_q;
				off_b = row_q;
			end
		endcase
	end

	assign cx16 = {cx_q[14], cx_q};
	assign cy16 = {cy_q[14], cy_q};
	assign r16  = {8'd0, r_q};
	assign a16  = {8'd0, off_a};
	assign b16  = {8'd0, off_b};
	// left half: base cx-1, walks -x; bottom half: base cy+r-1, walks -y
	assign px_w = quad_q[1] ? (cx16 - 16'd1 - a16) : (cx16 + a16);
	assign py_w = quad_q[0] ? (cy16 + r16 - 16'd1 - b16) : (cy16 - r16 + b16);

	assign stat.active    = active_q;
	assign stat.phase     = phase_q;
	assign stat.col_ge_r  = col_q >= r_q;
	assign stat.row_ge_r  = row_q >= r_q;
	assign stat.ol_end    = ({1'b0, col_q} + {1'b0, row_new}) >= {1'b0, r_q};
	assign stat.fill      = fill_q;
	assign stat.quad_last = (quad_q == 2'd3);
	assign stat.span_more = spc_q < rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			quad_q   <= 2'd0;
			phase_q  <= cqr_pkg::PH_OUTLINE;
			col_q    <= 8'd0;
			row_q    <= 8'd0;
			spc_q    <= 8'd0;
		end else if (cmd.start) begin
			active_q <= 1'b1;
			quad_q   <= 2'd0;
			phase_q  <= cqr_pkg::PH_OUTLINE;
			col_q    <= 8'd0;
			row_q    <= 8'd0;
			spc_q    <= 8'd0;
		end else begin
			if (cmd.emit_done) begin
				active_q <= 1'b0;
			end
			if (cmd.ol_cmp) begin
				row_q <= row_new;
			end
			if (cmd.fill_begin) begin
				phase_q <= cqr_pkg::PH_FILL;
				row_q   <= 8'd1;
				spc_q   <= 8'd0;
			end
			if (cmd.next_row) begin
				row_q <= row_q + 8'd1;
				spc_q <= 8'd0;
			end
			if (cmd.next_quad) begin
				quad_q  <= quad_q + 2'd1;
				phase_q <= cqr_pkg::PH_OUTLINE;
				col_q   <= 8'd0;
				row_q   <= 8'd0;
				spc_q   <= 8'd0;
			end
			if (cmd.emit_pix) begin
				case (phase_q)
					cqr_pkg::PH_OUTLINE: phase_q <= cqr_pkg::PH_MIRROR;
					cqr_pkg::PH_MIRROR: begin
						phase_q <= cqr_pkg::PH_OUTLINE;
						col_q   <= col_q + 8'd1;
					end
					default: spc_q <= spc_q + 8'd1;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			cx_q    <= center_x;
			cy_q    <= center_y;
			r_q     <= r_sat;
			color_q <= color;
			fill_q  <= fill_enable;
			r_sq_q  <= {8'd0, r_sat} * {8'd0, r_sat};
		end
		c_sq_q <= {8'd0, col_q} * {8'd0, col_q};
		h_sq_q <= {8'd0, h_w} * {8'd0, h_w};
		if (cmd.emit_pix) begin
			pixel_x     <= px_w;
			pixel_y     <= py_w;
			pixel_color <= color_q;
			done_res    <= 1'b0;
		end else if (cmd.emit_done) begin
			pixel_x     <= 16'sd0;
			pixel_y     <= 16'sd0;
			pixel_color <= 32'd0;
			done_res    <= 1'b1;
		end
	end

	// span widths per row, one write per cycle, registered read
	always_ff @(posedge clk) begin
		if (cmd.wr_a) begin
			span_mem[row_q[SPAN_AW-1:0]] <= col_q;
		end else if (cmd.wr_b) begin
			span_mem[mir_b[SPAN_AW-1:0]] <= mir_a;
		end
		rd_q <= span_mem[row_q[SPAN_AW-1:0]];
	end

endmodule

>>> hdl/circle_quadrant_rasterizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_quadrant_rasterizer_unit
// Circle rasterizer: a start transfer latches the circle, each step transfer
// returns the next pixel (outline, then optional fill spans) per quadrant, or the done marker.
// ----------------------------------------------------------------------------
//
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------------
//  in      | in_valid / in_stall    | op, center_x, center_y, radius, color,
//          |                        | fill_enable
//  out     | out_valid / out_stall  | pixel_x, pixel_y, pixel_color, done_res
//
// Each step transfer is walked by the sequencer from dispatch to one emit: a
// mirrored outline pixel goes straight to emit, a first outline pixel passes
// the row compare and both span writes, a fill pixel a span read. An empty or
// finished fill row adds a span read and a dispatch, a quadrant change a
// quadrant end and a dispatch, and leaving the outline an end check (after the
// row compare when that ends it), plus a dispatch when fill follows.
// The walk goes one step at a time through the square terms (one registered
// multiply stage) and the span memory. A start transfer gives no result; a step
// while idle is dropped. The span memory needs no clearing pass: every row read
// in fill was written by the same quadrant's outline. arst_n clears the sequencer,
// the walk counters and out_valid. The output register holds a result under
// out_stall while the next input transfer is taken; the walk waits only when it has a new result to load.
//
module circle_quadrant_rasterizer_unit #(
	parameter int unsigned MAX_RADIUS = 255
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               op,
	input  logic signed [14:0] center_x,
	input  logic signed [14:0] center_y,
	input  logic [7:0]         radius,
	input  logic [31:0]        color,
	input  logic               fill_enable,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] pixel_x,
	output logic signed [15:0] pixel_y,
	output logic [31:0]        pixel_color,
	output logic               done_res
);

	cqr_pkg::cqr_cmd_t  cmd;
	cqr_pkg::cqr_stat_t stat;

	// sequencer: handshakes and walk order
	cqr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// geometry, span memory, output register
	cqr_datapath #(
		.MAX_RADIUS (MAX_RADIUS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.center_x    (center_x),
		.center_y    (center_y),
		.radius      (radius),
		.color       (color),
		.fill_enable (fill_enable),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_color (pixel_color),
		.done_res    (done_res)
	);

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for circle_quadrant_rasterizer_unit. A stimulus queue
// is filled up front: directed circles first, then random circles with
// random centers, colors and fill. Most of these are walked to the done
// marker, and some are cut short by a restart. A predictor follows the
// accepted input transfers through the quadrant walk and the span table and
// queues each pixel as it is expected. The monitor checks every output
// transfer against that queue.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int GEN         = 0;    // walk copy used while building stimulus
	localparam int CHK         = 1;    // walk copy advanced on accepted transfers
	localparam int QUIET_LIMIT = 4000; // cycles with no transfer on either side
	localparam int DRAIN_WAIT  = 64;   // tail after the last expected pixel
	localparam int WORK_ITEMS  = 1000;

	typedef struct packed {
		logic               hold;  // hold off until every pixel due has arrived
		logic               op;
		logic signed [14:0] cx;
		logic signed [14:0] cy;
		logic [7:0]         r;
		logic [31:0]        color;
		logic               fill;
	} circle_req_t;

	typedef struct packed {
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic [31:0]        color;
		logic               done;
	} pixel_t;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               in_valid    = 1'b0;
	logic               in_stall;
	logic               op          = cqr_pkg::OP_STEP;
	logic signed [14:0] center_x    = '0;
	logic signed [14:0] center_y    = '0;
	logic [7:0]         radius      = '0;
	logic [31:0]        color       = '0;
	logic               fill_enable = 1'b0;
	logic               out_valid;
	logic               out_stall   = 1'b0;
	logic signed [15:0] pixel_x;
	logic signed [15:0] pixel_y;
	logic [31:0]        pixel_color;
	logic               done_res;

	// Two copies of the walk state: GEN runs ahead while the stimulus is built,
	// so a circle can be stepped exactly up to its done marker; CHK follows
	// the accepted input transfers and produces the expected pixels.
	bit          w_active[2];
	int          w_cx[2];
	int          w_cy[2];
	int          w_r[2];
	logic [31:0] w_color[2];
	bit          w_fill[2];
	int          w_quad[2];
	logic [1:0]  w_phase[2];
	int          w_col[2];
	int          w_row[2];
	int          w_scol[2];
	int          w_span[2][256];

	circle_req_t reqs_pending[$];
	pixel_t      pixels_due[$];
	circle_req_t cur_req;
	circle_req_t nxt_req;
	pixel_t      chk_pix;
	pixel_t      want;
	bit          send_idle;
	int          n_err     = 0;
	int          n_work    = 0;
	int          quiet     = 0;
	int          cycle_cnt = 0;
	logic        calm;

	// no idling on either side inside this window
	assign calm = (cycle_cnt >= 2000 && cycle_cnt < 4000);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	circle_quadrant_rasterizer_unit uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.center_x    (center_x),
		.center_y    (center_y),
		.radius      (radius),
		.color       (color),
		.fill_enable (fill_enable),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_color (pixel_color),
		.done_res    (done_res)
	);

	// pixel with coordinates wrapped to the output width
	function automatic pixel_t pixel_at(input int x, input int y, input logic [31:0] c);
		pixel_t p;
		p.px    = x[15:0];
		p.py    = y[15:0];
		p.color = c;
		p.done  = 1'b0;
		return p;
	endfunction

	// Advance walk copy m by one input item. Returns 1 when the item yields a
	// pixel or the done marker, placed in res.
	function automatic bit walk_circle(input int m, input circle_req_t it, output pixel_t res);
		int r, cx, cy, bx, by, mx, my, c, h, rw;
		bit quad_end, ol_end;
		res = '0;
		if (it.op == cqr_pkg::OP_START) begin
			w_cx[m]     = int'(it.cx);
			w_cy[m]     = int'(it.cy);
			w_r[m]      = int'(it.r);
			w_color[m]  = it.color;
			w_fill[m]   = it.fill;
			w_quad[m]   = 0;
			w_phase[m]  = cqr_pkg::PH_OUTLINE;
			w_col[m]    = 0;
			w_row[m]    = 0;
			w_scol[m]   = 0;
			w_active[m] = 1'b1;
			for (int i = 0; i < 256; i++)
				w_span[m][i] = 0;
			return 1'b0;
		end
		// a step with no circle in progress is dropped
		if (!w_active[m])
			return 1'b0;
		while (1) begin
			r  = w_r[m];
			cx = w_cx[m];
			cy = w_cy[m];
			// quadrant origin and walk direction: right half then left half,
			// top then bottom within each half
			bx = (w_quad[m] >= 2) ? cx - 1 : cx;
			by = (w_quad[m] % 2 == 0) ? cy - r : cy + r - 1;
			mx = (w_quad[m] >= 2) ? -1 : 1;
			my = (w_quad[m] % 2 == 0) ? 1 : -1;
			quad_end = 1'b0;
			case (w_phase[m])
				cqr_pkg::PH_OUTLINE: begin
					c = w_col[m];
					ol_end = 1'b0;
					if (c >= r) begin
						ol_end = 1'b1;
					end else begin
						h = r - w_row[m];
						if (c * c + h * h - 1 > r * r)
							w_row[m] += 1;
						if (c >= r - w_row[m])
							ol_end = 1'b1;
					end
					if (!ol_end) begin
						rw = w_row[m];
						// span widths for the row and its mirror
						w_span[m][rw]        = c;
						w_span[m][r - c - 1] = r - rw - 1;
						res = pixel_at(bx + c * mx, by + rw * my, w_color[m]);
						w_phase[m] = cqr_pkg::PH_MIRROR;
						return 1'b1;
					end
					if (w_fill[m]) begin
						w_phase[m] = cqr_pkg::PH_FILL;
						w_row[m]   = 1;
						w_scol[m]  = 0;
					end else begin
						quad_end = 1'b1;
					end
				end
				cqr_pkg::PH_MIRROR: begin
					c  = w_col[m];
					rw = w_row[m];
					res = pixel_at(bx + (r - rw - 1) * mx, by + (r - c - 1) * my,
						w_color[m]);
					w_col[m] += 1;
					w_phase[m] = cqr_pkg::PH_OUTLINE;
					return 1'b1;
				end
				cqr_pkg::PH_FILL: begin
					if (w_row[m] >= r) begin
						quad_end = 1'b1;
					end else if (w_scol[m] < w_span[m][w_row[m]]) begin
						res = pixel_at(bx + w_scol[m] * mx, by + w_row[m] * my, w_color[m]);
						w_scol[m] += 1;
						return 1'b1;
					end else begin
						// row done or empty: move on without a pixel
						w_row[m] += 1;
						w_scol[m] = 0;
					end
				end
				default: quad_end = 1'b1;
			endcase
			if (quad_end) begin
				if (w_quad[m] >= 3) begin
					w_active[m] = 1'b0;
					res = '0;
					res.done = 1'b1;
					return 1'b1;
				end
				w_quad[m] += 1;
				w_phase[m] = cqr_pkg::PH_OUTLINE;
				w_col[m]   = 0;
				w_row[m]   = 0;
				w_scol[m]  = 0;
			end
		end
		return 1'b0;
	endfunction

	// Queue one input item; returns 1 if it ends the circle with the done marker.
	function automatic bit queue_req(input logic op_v, input logic signed [14:0] x,
		input logic signed [14:0] y, input logic [7:0] r, input logic [31:0] c,
		input logic fl, input logic hold);
		circle_req_t it;
		pixel_t      p;
		bit          got;
		it.hold  = hold;
		it.op    = op_v;
		it.cx    = x;
		it.cy    = y;
		it.r     = r;
		it.color = c;
		it.fill  = fl;
		// steps that the block only drops do not count as work
		if (op_v == cqr_pkg::OP_START || w_active[GEN])
			n_work++;
		reqs_pending.push_back(it);
		got = walk_circle(GEN, it, p);
		return got && p.done;
	endfunction

	// step with random don't-care payload, so every input bit toggles
	function automatic bit queue_step();
		return queue_req(cqr_pkg::OP_STEP, 15'($urandom), 15'($urandom), 8'($urandom),
			$urandom, 1'($urandom), 1'b0);
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus build, reset, end of run
	// ------------------------------------------------------------------------
	initial begin
		int               k;
		logic [7:0]       r;
		logic             fl;
		bit               cut;
		logic signed [14:0] x;
		logic signed [14:0] y;

		// directed: step before any start, radius zero, steps after done
		void'(queue_step());
		void'(queue_req(cqr_pkg::OP_START, 15'h3FFF, 15'h4000, 8'd0, 32'hFFFF_FFFF,
			1'b1, 1'b0));
		void'(queue_step());
		void'(queue_step());
		// radius one with fill, sent only after everything due has drained
		void'(queue_req(cqr_pkg::OP_START, 15'h4000, 15'h3FFF, 8'd1, 32'h0, 1'b1, 1'b1));
		while (!queue_step());
		// largest radius, then a restart in the middle of the walk
		void'(queue_req(cqr_pkg::OP_START, 15'h3FFF, 15'h3FFF, 8'd255, 32'hA5A5_5A5A,
			1'b1, 1'b0));
		repeat (4) void'(queue_step());
		void'(queue_req(cqr_pkg::OP_START, 15'h4000, 15'h4000, 8'd255, 32'h5A5A_A5A5,
			1'b0, 1'b0));
		repeat (4) void'(queue_step());

		// random circles: mostly small and walked to done; the large ones and a
		// few others are cut short by the next start
		while (n_work < WORK_ITEMS) begin
			k = $urandom_range(99);
			if (k < 55)
				r = 8'($urandom_range(6));
			else if (k < 85)
				r = 8'($urandom_range(20, 7));
			else if (k < 95)
				r = 8'($urandom_range(60, 21));
			else
				r = 8'($urandom_range(255, 100));
			// fill grows with r squared, so keep it to modest radii
			if (r <= 10)
				fl = 1'($urandom_range(1));
			else
				fl = (r <= 20 && $urandom_range(9) == 0);
			cut = (r >= 100) || ($urandom_range(9) == 0);
			if ($urandom_range(7) == 0)
				x = $urandom_range(1) ? 15'h3FFF : 15'h4000;
			else
				x = 15'($urandom);
			if ($urandom_range(7) == 0)
				y = $urandom_range(1) ? 15'h3FFF : 15'h4000;
			else
				y = 15'($urandom);
			void'(queue_req(cqr_pkg::OP_START, x, y, r, $urandom, fl,
				$urandom_range(49) == 0));
			if (cut) begin
				repeat ($urandom_range(r >= 100 ? 400 : 20)) void'(queue_step());
			end else begin
				while (!queue_step());
				// stray steps after done are dropped by the block
				if ($urandom_range(9) == 0)
					repeat ($urandom_range(3, 1)) void'(queue_step());
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (reqs_pending.size() != 0 || in_valid)
			@(posedge clk);
		while (pixels_due.size() != 0)
			@(posedge clk);
		// let any stray result show up before the verdict
		repeat (DRAIN_WAIT) @(posedge clk);
		if (n_err == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Driver: predicts on each accepted input transfer, then presents the
	// next item, idles, or holds for a drain before a marked start.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				if (walk_circle(CHK, cur_req, chk_pix))
					pixels_due.push_back(chk_pix);
			end
			// slot is free when nothing is presented or it was just taken
			if (!in_valid || !in_stall) begin
				send_idle = !calm && ($urandom_range(99) < 20);
				if (reqs_pending.size() != 0 && !send_idle &&
				    !(reqs_pending[0].hold && pixels_due.size() != 0)) begin
					nxt_req     = reqs_pending.pop_front();
					cur_req     <= nxt_req;
					op          <= nxt_req.op;
					center_x    <= nxt_req.cx;
					center_y    <= nxt_req.cy;
					radius      <= nxt_req.r;
					color       <= nxt_req.color;
					fill_enable <= nxt_req.fill;
					in_valid    <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: random stall, field-by-field check of each output transfer
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pixels_due.size() == 0) begin
					$error("unexpected result: x=%0d y=%0d color=%h done=%b",
						pixel_x, pixel_y, pixel_color, done_res);
					n_err++;
				end else begin
					want = pixels_due.pop_front();
					if (pixel_x !== want.px) begin
						$error("pixel_x: expected %0d, got %0d", want.px, pixel_x);
						n_err++;
					end
					if (pixel_y !== want.py) begin
						$error("pixel_y: expected %0d, got %0d", want.py, pixel_y);
						n_err++;
					end
					if (pixel_color !== want.color) begin
						$error("pixel_color: expected %h, got %h", want.color, pixel_color);
						n_err++;
					end
					if (done_res !== want.done) begin
						$error("done_res: expected %b, got %b", want.done, done_res);
						n_err++;
					end
				end
			end
			out_stall <= !calm && ($urandom_range(99) < 20);
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: a hang shows up as a long run of cycles with no transfer
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

endmodule
